/* hdl/matrix4x4_row_multiply_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the 4x4 row multiply modules.
// Both expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef MATRIX4X4_ROW_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_ROW_MULTIPLY_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define MRM_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define MRM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/mrm_pkg.sv */
// ---------------------------------------------------------------------------
// mrm_pkg
// Types and constants for the 4x4 row multiply block.
// ---------------------------------------------------------------------------
package mrm_pkg;

  localparam int ElemW           = 32;
  localparam int NumCols         = 4;
  localparam int MatEntries      = NumCols * NumCols;
  localparam int ProdW           = 2 * ElemW;
  localparam int PairW           = ProdW + 1;
  localparam int SumW            = ProdW + 2;
  localparam int FracBitsDefault = 16;
  localparam int QueueDepth      = 4;

  localparam logic [ElemW-1:0] ElemMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] ElemMin = {1'b1, {(ElemW-1){1'b0}}};

  // Input item as it arrives on the port
  typedef struct packed {
    logic              cmd;
    logic [1:0]        row;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
  } mrm_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]         row_tag;
    logic signed [31:0] out0;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic signed [31:0] out3;
    logic               saturated;
  } mrm_out_t;

  // Operation decoded by the front end
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MUL  = 1'b1
  } mrm_op_t;

  // Queue entry handed from front end to back end
  typedef struct packed {
    mrm_op_t                       op;
    logic [1:0]                    row;
    logic [NumCols-1:0][ElemW-1:0] elems;
  } mrm_cmd_t;

endpackage

/* hdl/mrm_front.sv */
// ---------------------------------------------------------------------------
// mrm_front
// Accepts input items, decodes load or multiply, and queues them in order.
// ---------------------------------------------------------------------------
`include "matrix4x4_row_multiply_assert.svh"

module mrm_front import mrm_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mrm_in_t  in_data,
  output logic     q_valid,
  output mrm_cmd_t q_head,
  input  logic     q_pop
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  mrm_cmd_t          q_mem_r [QDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              push;
  mrm_cmd_t          entry;

  // Decode the incoming item
  always_comb begin
    entry.row   = in_data.row;
    entry.elems = {in_data.elem3, in_data.elem2, in_data.elem1, in_data.elem0};
    case (in_data.cmd)
      OP_MUL:  entry.op = OP_MUL;
      default: entry.op = OP_LOAD;
    endcase
  end

  assign in_stall = (count_r == CntW'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_head   = q_mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the decoded item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  `MRM_ASSERT_SAME(a_pop_nonempty, q_pop, count_r != '0, "pop from empty queue")
  `MRM_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CntW'(QDepth), "queue count overflow")
  `MRM_ASSERT_NEXT(a_push_count, push && !q_pop, count_r == $past(count_r) + 1'b1, "push lost")

endmodule

/* hdl/mrm_back.sv */
// ---------------------------------------------------------------------------
// mrm_back
// Holds the right matrix, applies loads in order, and runs multiply rows
// through a multiply, add, add, saturate pipeline into the output register.
// ---------------------------------------------------------------------------
`include "matrix4x4_row_multiply_assert.svh"

module mrm_back import mrm_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  mrm_cmd_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output mrm_out_t out_data
);

  logic signed [ElemW-1:0] mat_r [MatEntries];

  logic                    s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic [1:0]              s1_row_r, s2_row_r, s3_row_r;
  logic signed [ProdW-1:0] s1_prod_r [NumCols][NumCols];
  logic signed [PairW-1:0] s2_lo_r [NumCols];
  logic signed [PairW-1:0] s2_hi_r [NumCols];
  logic signed [SumW-1:0]  s3_sum_r [NumCols];
  mrm_out_t                out_data_r, out_nxt;

  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic ld_pop, issue_mul;

  logic signed [SumW-1:0]  shifted [NumCols];
  logic [ElemW-1:0]        res [NumCols];
  logic [NumCols-1:0]      clip;

  // Ready chain from the output register back to the queue
  assign out_ready = !out_valid_r || !out_stall;
  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;

  assign ld_pop    = q_valid && (q_head.op == OP_LOAD);
  assign issue_mul = q_valid && (q_head.op == OP_MUL) && s1_ready;
  assign q_pop     = ld_pop || issue_mul;

  // Write one row of the right matrix on a load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MatEntries; i++) begin
        mat_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MatEntries; i++) begin
        if (ld_pop && (q_head.row == 2'(i >> 2))) begin
          mat_r[i] <= q_head.elems[2'(i)];
        end
      end
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= issue_mul;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // Shift each column sum and clip it to 32 bits
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      shifted[c] = s3_sum_r[c] >>> FracBits;
      if (!shifted[c][SumW-1] && (|shifted[c][SumW-2:ElemW-1])) begin
        res[c]  = ElemMax;
        clip[c] = 1'b1;
      end else if (shifted[c][SumW-1] && !(&shifted[c][SumW-2:ElemW-1])) begin
        res[c]  = ElemMin;
        clip[c] = 1'b1;
      end else begin
        res[c]  = shifted[c][ElemW-1:0];
        clip[c] = 1'b0;
      end
    end
    out_nxt.row_tag   = s3_row_r;
    out_nxt.out0      = res[0];
    out_nxt.out1      = res[1];
    out_nxt.out2      = res[2];
    out_nxt.out3      = res[3];
    out_nxt.saturated = |clip;
  end

  // Pipeline data: products, pair sums, column sums, result
  always_ff @(posedge clk) begin
    if (s1_ready && issue_mul) begin
      s1_row_r <= q_head.row;
      for (int k = 0; k < NumCols; k++) begin
        for (int c = 0; c < NumCols; c++) begin
          s1_prod_r[k][c] <= ProdW'(signed'(q_head.elems[k])) * ProdW'(mat_r[k * NumCols + c]);
        end
      end
    end
    if (s2_ready && s1_valid_r) begin
      s2_row_r <= s1_row_r;
      for (int c = 0; c < NumCols; c++) begin
        s2_lo_r[c] <= PairW'(s1_prod_r[0][c]) + PairW'(s1_prod_r[1][c]);
        s2_hi_r[c] <= PairW'(s1_prod_r[2][c]) + PairW'(s1_prod_r[3][c]);
      end
    end
    if (s3_ready && s2_valid_r) begin
      s3_row_r <= s2_row_r;
      for (int c = 0; c < NumCols; c++) begin
        s3_sum_r[c] <= SumW'(s2_lo_r[c]) + SumW'(s2_hi_r[c]);
      end
    end
    if (out_ready && s3_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MRM_ASSERT_NEXT(a_mul_enters, issue_mul, s1_valid_r, "multiply row lost at first stage")
  `MRM_ASSERT_NEXT(a_s3_holds, s3_valid_r && !s3_ready, s3_valid_r, "sum stage dropped a row")
  `MRM_ASSERT_NEXT(a_load_write, ld_pop,
    mat_r[{$past(q_head.row), 2'b00}] == $past(q_head.elems[0]), "load not stored")

endmodule

/* hdl/matrix4x4_row_multiply.sv */
// ---------------------------------------------------------------------------
// matrix4x4_row_multiply
// Row-at-a-time 4x4 matrix multiply in signed Q16.16 with saturation.
// ---------------------------------------------------------------------------
// Load items (cmd 0) write one row of the right matrix, which resets to all
// zeros; multiply items (cmd 1) give one result row, the left row times the
// stored matrix, tagged with the item's row. Items are taken in order, one
// per cycle sustained while out_stall stays low, loads and multiplies mixed
// freely: sixteen multiplier lanes work on one row at once. A multiply row
// passes through the queue, products, pair sums, column sums, then shift
// and saturate into the output register that drives out_valid. A four-entry
// queue sits behind the input; in_stall rises only when it is full.
// ---------------------------------------------------------------------------
module matrix4x4_row_multiply import mrm_pkg::*; #(
  parameter int FracBits = FracBitsDefault,
  parameter int QDepth   = QueueDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mrm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mrm_out_t out_data
);

  logic     q_valid;
  logic     q_pop;
  mrm_cmd_t q_head;

  // Accept and decode items
  mrm_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Apply loads and compute product rows
  mrm_back #(
    .FracBits (FracBits)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/matrix4x4_row_multiply_checker.sv */
// ---------------------------------------------------------------------------
// matrix4x4_row_multiply_checker
// Watches both channels of the row multiply block and checks each result.
// ---------------------------------------------------------------------------
// The checker keeps its own copy of the right matrix. Every load item
// updates that copy. Every multiply item queues the result row that this
// copy predicts. Each result item that leaves the block is compared field
// by field with the oldest queued row.
// ---------------------------------------------------------------------------
module matrix4x4_row_multiply_checker import mrm_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  mrm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  mrm_out_t out_data,
  output int       fail_count,
  output int       rows_due,
  output int       loads_seen,
  output int       products_seen,
  output int       clips_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Saturation bounds, sign-extended to the sum width
  localparam logic signed [SumW-1:0] SumMax = {{(SumW-ElemW){1'b0}}, ElemMax};
  localparam logic signed [SumW-1:0] SumMin = {{(SumW-ElemW){1'b1}}, ElemMin};

  logic signed [ElemW-1:0] right_store [MatEntries];
  mrm_out_t                product_rows_due [$];

  // Multiply one left row by the stored matrix: exact sum, shift, clip
  function automatic mrm_out_t multiply_row(mrm_in_t item);
    logic signed [ElemW-1:0] lhs [NumCols];
    logic signed [ElemW-1:0] col_val [NumCols];
    logic signed [ProdW-1:0] prod;
    logic signed [SumW-1:0]  acc;
    logic signed [SumW-1:0]  scaled;
    mrm_out_t                res;
    int                      c;
    int                      k;
    lhs[0] = item.elem0;
    lhs[1] = item.elem1;
    lhs[2] = item.elem2;
    lhs[3] = item.elem3;
    res = '0;
    for (c = 0; c < NumCols; c++) begin
      acc = '0;
      for (k = 0; k < NumCols; k++) begin
        prod = lhs[k] * right_store[k * NumCols + c];
        acc  = acc + prod;
      end
      scaled = acc >>> FracBits;
      if (scaled > SumMax) begin
        col_val[c]    = ElemMax;
        res.saturated = 1'b1;
      end else if (scaled < SumMin) begin
        col_val[c]    = ElemMin;
        res.saturated = 1'b1;
      end else begin
        col_val[c] = scaled[ElemW-1:0];
      end
    end
    res.row_tag = item.row;
    res.out0    = col_val[0];
    res.out1    = col_val[1];
    res.out2    = col_val[2];
    res.out3    = col_val[3];
    return res;
  endfunction

  // Count a wrong field; report only the first few
  task automatic check_field(string what, logic [ElemW-1:0] want, logic [ElemW-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    mrm_out_t want;
    int       base;
    int       i;
    if (!rst_n) begin
      // Clear the matrix copy and drop anything in flight
      for (i = 0; i < MatEntries; i++)
        right_store[i] = '0;
      product_rows_due.delete();
    end else begin
      // Compare a result item with the oldest expected row
      if (out_valid && !out_stall) begin
        if (product_rows_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: %p", $realtime, out_data);
        end else begin
          want = product_rows_due.pop_front();
          check_field("row_tag", ElemW'(want.row_tag), ElemW'(out_data.row_tag));
          check_field("out0", want.out0, out_data.out0);
          check_field("out1", want.out1, out_data.out1);
          check_field("out2", want.out2, out_data.out2);
          check_field("out3", want.out3, out_data.out3);
          check_field("saturated", ElemW'(want.saturated), ElemW'(out_data.saturated));
        end
      end
      // Update the matrix copy or predict a product row
      if (in_valid && !in_stall) begin
        if (in_data.cmd == OP_LOAD) begin
          base = in_data.row * NumCols;
          right_store[base]     = in_data.elem0;
          right_store[base + 1] = in_data.elem1;
          right_store[base + 2] = in_data.elem2;
          right_store[base + 3] = in_data.elem3;
          loads_seen++;
        end else begin
          want = multiply_row(in_data);
          product_rows_due = {product_rows_due, want};
          products_seen++;
          if (want.saturated)
            clips_seen++;
        end
      end
    end
    rows_due = product_rows_due.size();
  end

endmodule

/* tb/matrix4x4_row_multiply_tb.sv */
// ---------------------------------------------------------------------------
// matrix4x4_row_multiply_tb
// Stimulus and verdict for the 4x4 row multiply block.
// ---------------------------------------------------------------------------
// A short directed run covers multiplies against the cleared matrix, a
// partly loaded matrix, identity and half-scale matrices, and sums that
// clip high, clip low or land exactly on the limits. Random load and
// multiply sequences follow, with bursts of idle cycles on the input and
// stalls on the output. The checker beside the block does the comparing.
// ---------------------------------------------------------------------------
module matrix4x4_row_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrm_pkg::*;

  localparam int RandomItems = 1125;
  localparam int CalmTail    = 150;

  localparam logic signed [ElemW-1:0] One     = 32'sh0001_0000;
  localparam logic signed [ElemW-1:0] Half    = 32'sh0000_8000;
  localparam logic signed [ElemW-1:0] Epsilon = 32'sh0000_0001;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  mrm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mrm_out_t out_data;

  int fail_count;
  int rows_due;
  int loads_seen;
  int products_seen;
  int clips_seen;

  int sent       = 0;
  int gap_odds   = 6;
  int stall_odds = 6;
  int stall_left = 0;

  matrix4x4_row_multiply DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  matrix4x4_row_multiply_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .rows_due      (rows_due),
    .loads_seen    (loads_seen),
    .products_seen (products_seen),
    .clips_seen    (clips_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result channel in bursts of random length
  always @(posedge clk) begin
    if (!rst_n || stall_odds == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(1, stall_odds) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Mix extremes, unit values, small fixed-point values and raw patterns
  function automatic logic signed [ElemW-1:0] pick_elem();
    logic signed [ElemW-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = ElemMax;
      1:       v = ElemMin;
      2:       v = '0;
      3:       v = One;
      4:       v = -One;
      5:       v = -Epsilon;
      6, 7, 8: begin
        v = $urandom();
        v = v >>> $urandom_range(8, 16);
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Hold the item until it is accepted, after an optional idle burst
  task automatic push_item(input mrm_in_t item);
    int gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_row(input mrm_op_t op, input logic [1:0] row,
                          input logic signed [ElemW-1:0] e0, input logic signed [ElemW-1:0] e1,
                          input logic signed [ElemW-1:0] e2, input logic signed [ElemW-1:0] e3);
    mrm_in_t item;
    item.cmd   = op;
    item.row   = row;
    item.elem0 = e0;
    item.elem1 = e1;
    item.elem2 = e2;
    item.elem3 = e3;
    push_item(item);
  endtask

  task automatic send_random(input mrm_op_t op, input logic [1:0] row);
    send_row(op, row, pick_elem(), pick_elem(), pick_elem(), pick_elem());
  endtask

  // Ease off idling in stretches; none at all near the end
  task automatic set_idle_phase();
    if (sent >= RandomItems - CalmTail) begin
      gap_odds   = 0;
      stall_odds = 0;
    end else begin
      case ((sent / 150) % 3)
        0:       begin gap_odds = 4;  stall_odds = 4;  end
        1:       begin gap_odds = 14; stall_odds = 10; end
        default: begin gap_odds = 0;  stall_odds = 0;  end
      endcase
    end
  endtask

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int            r;
    int            n;
    int            target;
    mrm_in_t       noise;
    logic [159:0]  noise_bits;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Multiply against the cleared matrix
    send_row(OP_MUL, 2'd0, ElemMax, ElemMax, ElemMax, ElemMax);
    send_row(OP_MUL, 2'd3, ElemMin, ElemMin, ElemMin, ElemMin);
    // Partly loaded matrix: only row 1 column 0 set; hit both limits exactly
    send_row(OP_LOAD, 2'd1, One, '0, '0, '0);
    send_row(OP_MUL, 2'd2, '0, ElemMax, '0, '0);
    send_row(OP_MUL, 2'd1, '0, ElemMin, '0, '0);
    // Identity passes the left row through
    for (r = 0; r < NumCols; r++)
      send_row(OP_LOAD, 2'(r), (r == 0) ? One : '0, (r == 1) ? One : '0,
               (r == 2) ? One : '0, (r == 3) ? One : '0);
    send_row(OP_MUL, 2'd0, ElemMax, ElemMin, Epsilon, -Epsilon);
    // Half-scale row 0: a negative fraction rounds down
    send_row(OP_LOAD, 2'd0, Half, Half, Half, Half);
    send_row(OP_MUL, 2'd2, -Epsilon, '0, '0, '0);
    // All-max matrix: clip high, clip low, and cancel out
    for (r = 0; r < NumCols; r++)
      send_row(OP_LOAD, 2'(r), ElemMax, ElemMax, ElemMax, ElemMax);
    send_row(OP_MUL, 2'd1, ElemMax, ElemMax, ElemMax, ElemMax);
    send_row(OP_MUL, 2'd3, ElemMin, ElemMin, ElemMin, ElemMin);
    send_row(OP_MUL, 2'd0, ElemMax, ElemMin, ElemMax, ElemMin);
    // All-min matrix: the widest positive sum
    for (r = 0; r < NumCols; r++)
      send_row(OP_LOAD, 2'(r), ElemMin, ElemMin, ElemMin, ElemMin);
    send_row(OP_MUL, 2'd2, ElemMin, ElemMin, ElemMin, ElemMin);
    send_row(OP_MUL, 2'd1, Epsilon, '0, '0, '0);

    // Random load/multiply sequences with some unordered noise
    target = sent + RandomItems;
    while (sent < target) begin
      set_idle_phase();
      if ($urandom_range(0, 4) != 0) begin
        n = $urandom_range(0, 4);
        r = $urandom_range(0, 3);
        repeat (n) begin
          send_random(OP_LOAD, 2'(r));
          r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : (r + 1) % NumCols;
        end
        n = $urandom_range(1, 6);
        repeat (n) send_random(OP_MUL, 2'($urandom_range(0, 3)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          noise_bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
          noise      = noise_bits[$bits(mrm_in_t)-1:0];
          push_item(noise);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding rows, then watch for strays
    while (rows_due != 0) @(negedge clk);
    repeat (12) @(posedge clk);

    $display("Ran %0d items: %0d matrix row loads, %0d row products (%0d clipped).",
             sent, loads_seen, products_seen, clips_seen);
    $display("Field mismatches or stray results: %0d.", fail_count);
    if (fail_count == 0 && rows_due == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
